@@ design/pdq_pkg.sv @@
`default_nettype none

package pdq_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int WORD_W         = 32;
  localparam int CFG_IDX_W      = 3;

  // current divider: |flux diff| (33 bits) << 20, padded to an even count
  localparam int NUM_SHIFT  = 20;
  localparam int DIV_BITS   = 54;
  localparam int DIV_STEPS  = DIV_BITS / 2;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RESISTANCE  = 3'd0,
    REG_IND_D       = 3'd1,
    REG_IND_Q       = 3'd2,
    REG_SAMPLE_TIME = 3'd3,
    REG_MAGNET_FLUX = 3'd4
  } cfg_reg_t;

  localparam logic [WORD_W-1:0] RESISTANCE_RST  = 32'd65536;
  localparam logic [WORD_W-1:0] INDUCTANCE_RST  = 32'd4294967;
  localparam logic [WORD_W-1:0] SAMPLE_TIME_RST = 32'd429497;
  localparam logic [WORD_W-1:0] MAGNET_FLUX_RST = 32'd0;

  typedef struct packed {
    logic signed [31:0] voltage_d;
    logic signed [31:0] voltage_q;
    logic signed [31:0] electrical_speed;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] current_d;
    logic signed [31:0] current_q;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic               start;
    logic signed [32:0] num;
    logic [31:0]        divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic               sat;
    logic signed [31:0] value;
  } div_res_t;

  typedef struct packed {
    logic               sat;
    logic signed [31:0] value;
  } sat_res_t;

  // clamp a 64-bit value to the signed range of sbits bits (sbits <= 32)
  function automatic sat_res_t sat_clamp(input logic signed [63:0] x, input int sbits);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    sat_res_t           r;
    hi = (64'sd1 <<< (sbits - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (x > hi) begin
      r.sat   = 1'b1;
      r.value = hi[31:0];
    end else if (x < lo) begin
      r.sat   = 1'b1;
      r.value = lo[31:0];
    end else begin
      r.sat   = 1'b0;
      r.value = x[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/pdq_div.sv @@
`default_nettype none

module pdq_div #(
  parameter int DATA_WIDTH = pdq_pkg::DATA_WIDTH_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire pdq_pkg::div_req_t req,
  output pdq_pkg::div_res_t   res
);
  import pdq_pkg::*;

  localparam int SatBits = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;

  logic                 busy_r;
  logic                 done_r;
  logic                 neg_r;
  logic                 zero_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [31:0]          dvs_r;
  logic [31:0]          rem_r;
  logic [DIV_BITS-1:0]  quo_r;

  logic [32:0]          mag;
  logic [DIV_BITS-1:0]  num_init;
  logic [32:0]          t1;
  logic [32:0]          t2;
  logic [31:0]          r1;
  logic [31:0]          rem_nxt;
  logic                 q1;
  logic                 q0;
  logic signed [63:0]   sq;
  sat_res_t             cl;

  assign mag      = req.num[32] ? 33'(-req.num) : 33'(req.num);
  assign num_init = {1'b0, mag, {NUM_SHIFT{1'b0}}};

  // two restoring steps a cycle; dividend bits leave at the top, quotient bits enter below
  always_comb begin
    t1 = {rem_r, quo_r[DIV_BITS-1]};
    if (t1 >= {1'b0, dvs_r}) begin
      r1 = 32'(t1 - {1'b0, dvs_r});
      q1 = 1'b1;
    end else begin
      r1 = t1[31:0];
      q1 = 1'b0;
    end
    t2 = {r1, quo_r[DIV_BITS-2]};
    if (t2 >= {1'b0, dvs_r}) begin
      rem_nxt = 32'(t2 - {1'b0, dvs_r});
      q0      = 1'b1;
    end else begin
      rem_nxt = t2[31:0];
      q0      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r  <= num_init;
      rem_r  <= '0;
      dvs_r  <= req.divisor;
      neg_r  <= req.num[32];
      zero_r <= (mag == 33'd0);
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_BITS-3:0], q1, q0};
      rem_r <= rem_nxt;
    end
  end

  // zero divisor leaves an all-ones quotient, which clamps with the right sign
  always_comb begin
    sq = neg_r ? -$signed({{(64-DIV_BITS){1'b0}}, quo_r})
               :  $signed({{(64-DIV_BITS){1'b0}}, quo_r});
    cl = sat_clamp(sq, SatBits);
    res.done  = done_r;
    res.sat   = !zero_r && cl.sat;
    res.value = zero_r ? 32'sd0 : cl.value;
  end

  a_start_loads : assert property (@(posedge clk) disable iff (!rst_n)
    req.start |=> busy_r && (cnt_r == '0))
    else $error("divider did not start");

  a_done_idle : assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("divider done while busy");

  a_cnt_range : assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cnt_r < DIV_CNT_W'(DIV_STEPS)))
    else $error("divider step count out of range");

endmodule

`default_nettype wire

@@ design/pdq_mul.sv @@
`default_nettype none

module pdq_mul (
  input  wire                clk,
  input  wire signed [32:0]  a,
  input  wire signed [32:0]  b,
  output logic signed [65:0] p_r
);

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

`default_nettype wire

@@ design/pmsm_dq_plant_model_step.sv @@
`default_nettype none
// dq-frame PMSM plant, one forward-Euler step per item.
// Input channel (in_valid/in_stall/in_data): d and q voltages and electrical
// speed. Result channel (out_valid/out_stall/out_data): d and q currents from
// the flux held before the step, plus a flag for any clamped value.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): resistance, both
// inductances, sample time and magnet flux; cfg_ready is always high, write
// only while no item is in flight. Unknown indexes are ignored.
// in_stall is high while an item is worked on, so a new item is taken only once
// the last one has been handed off. The work is two divisions on one shared
// divider (start, 27 radix-4 steps, result), eight passes of a single shared
// 33x33 multiplier, and the sign split, the flux update and the hand-off.
// A finished result sits in the output register until taken; the next item is
// accepted meanwhile, but its result waits until the register is free.
// Reset (rst_n, synchronous) clears both fluxes, loads the register defaults
// and empties the output register.
module pmsm_dq_plant_model_step #(
  parameter int DATA_WIDTH = pdq_pkg::DATA_WIDTH_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire pdq_pkg::in_item_t            in_data,
  output logic                              out_valid,
  input  wire                               out_stall,
  output pdq_pkg::out_item_t                out_data,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire [pdq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [pdq_pkg::WORD_W-1:0]         cfg_data
);
  import pdq_pkg::*;

  localparam int SatBits = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_DIVD = 8'b0000_0010,
    S_DIVQ = 8'b0000_0100,
    S_MUL  = 8'b0000_1000,
    S_ACC  = 8'b0001_0000,
    S_MAG  = 8'b0010_0000,
    S_UPD  = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  // multiplier passes
  typedef enum logic [2:0] {
    OP_R_ID  = 3'd0,
    OP_W_FQ  = 3'd1,
    OP_R_IQ  = 3'd2,
    OP_W_FD  = 3'd3,
    OP_HI_D  = 3'd4,
    OP_LO_D  = 3'd5,
    OP_HI_Q  = 3'd6,
    OP_LO_Q  = 3'd7
  } op_t;

  state_t             state_r, state_nxt;
  op_t                op_r;
  logic               go_r;

  logic [31:0]        resistance_r;
  logic [31:0]        ind_d_r;
  logic [31:0]        ind_q_r;
  logic [31:0]        ts_r;
  logic signed [31:0] mflux_r;
  logic signed [31:0] flux_d_r;
  logic signed [31:0] flux_q_r;

  logic signed [31:0] vd_r;
  logic signed [31:0] vq_r;
  logic signed [31:0] w_r;
  logic signed [31:0] cur_d_r;
  logic signed [31:0] cur_q_r;
  logic               sat_r;
  logic signed [63:0] acc_d_r;
  logic signed [63:0] acc_q_r;
  logic               sgn_d_r;
  logic               sgn_q_r;
  logic [63:0]        inc_d_r;
  logic [63:0]        inc_q_r;

  logic               out_valid_r;
  out_item_t          out_data_r;

  logic               accept;
  logic               out_load;
  div_req_t           div_req;
  div_res_t           div_res;
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] mul_p;
  logic signed [63:0] p64;
  logic [63:0]        p_hi;
  logic signed [63:0] next_d;
  logic signed [63:0] next_q;
  sat_res_t           cl_d;
  sat_res_t           cl_q;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_load  = (state_r == S_DONE) && !(out_valid_r && out_stall);

  // ---- configuration ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resistance_r <= RESISTANCE_RST;
      ind_d_r      <= INDUCTANCE_RST;
      ind_q_r      <= INDUCTANCE_RST;
      ts_r         <= SAMPLE_TIME_RST;
      mflux_r      <= MAGNET_FLUX_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RESISTANCE:  resistance_r <= cfg_data;
        REG_IND_D:       ind_d_r      <= cfg_data;
        REG_IND_Q:       ind_q_r      <= cfg_data;
        REG_SAMPLE_TIME: ts_r         <= cfg_data;
        REG_MAGNET_FLUX: mflux_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---- shared divider ----
  always_comb begin
    div_req.start   = go_r;
    div_req.num     = (state_r == S_DIVQ) ? 33'({flux_q_r[31], flux_q_r})
                                          : 33'({flux_d_r[31], flux_d_r} -
                                                 {mflux_r[31], mflux_r});
    div_req.divisor = (state_r == S_DIVQ) ? ind_q_r : ind_d_r;
  end

  pdq_div #(.DATA_WIDTH(DATA_WIDTH)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .res   (div_res)
  );

  // ---- shared multiplier ----
  always_comb begin
    case (op_r)
      OP_R_ID: begin
        mul_a = $signed({1'b0, resistance_r});
        mul_b = {cur_d_r[31], cur_d_r};
      end
      OP_W_FQ: begin
        mul_a = {w_r[31], w_r};
        mul_b = {flux_q_r[31], flux_q_r};
      end
      OP_R_IQ: begin
        mul_a = $signed({1'b0, resistance_r});
        mul_b = {cur_q_r[31], cur_q_r};
      end
      OP_W_FD: begin
        mul_a = {w_r[31], w_r};
        mul_b = {flux_d_r[31], flux_d_r};
      end
      OP_HI_D: begin
        mul_a = $signed({1'b0, acc_d_r[63:32]});
        mul_b = $signed({1'b0, ts_r});
      end
      OP_LO_D: begin
        mul_a = $signed({1'b0, acc_d_r[31:0]});
        mul_b = $signed({1'b0, ts_r});
      end
      OP_HI_Q: begin
        mul_a = $signed({1'b0, acc_q_r[63:32]});
        mul_b = $signed({1'b0, ts_r});
      end
      OP_LO_Q: begin
        mul_a = $signed({1'b0, acc_q_r[31:0]});
        mul_b = $signed({1'b0, ts_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  pdq_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  // every signed product fits 64 bits; lo*ts is unsigned and fills all 64
  assign p64  = mul_p[63:0];
  assign p_hi = {32'd0, mul_p[63:32]};

  // ---- flux update ----
  always_comb begin
    next_d = sgn_d_r ? ($signed({{32{flux_d_r[31]}}, flux_d_r}) - $signed(inc_d_r))
                     : ($signed({{32{flux_d_r[31]}}, flux_d_r}) + $signed(inc_d_r));
    next_q = sgn_q_r ? ($signed({{32{flux_q_r[31]}}, flux_q_r}) - $signed(inc_q_r))
                     : ($signed({{32{flux_q_r[31]}}, flux_q_r}) + $signed(inc_q_r));
    cl_d   = sat_clamp(next_d, SatBits);
    cl_q   = sat_clamp(next_q, SatBits);
  end

  // ---- sequencer ----
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = S_DIVD;
      S_DIVD: if (div_res.done) state_nxt = S_DIVQ;
      S_DIVQ: if (div_res.done) state_nxt = S_MUL;
      S_MUL:  state_nxt = S_ACC;
      S_ACC: begin
        if (op_r == OP_W_FD) state_nxt = S_MAG;
        else if (op_r == OP_LO_Q) state_nxt = S_UPD;
        else state_nxt = S_MUL;
      end
      S_MAG:  state_nxt = S_MUL;
      S_UPD:  state_nxt = S_DONE;
      S_DONE: if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_R_ID;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
      flux_d_r    <= '0;
      flux_q_r    <= '0;
    end else begin
      state_r <= state_nxt;
      go_r    <= accept || ((state_r == S_DIVD) && div_res.done);
      if (accept) op_r <= OP_R_ID;
      else if ((state_r == S_ACC) && (op_r != OP_LO_Q)) op_r <= op_t'(op_r + 3'd1);
      if (state_r == S_UPD) begin
        flux_d_r <= cl_d.value;
        flux_q_r <= cl_q.value;
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      vd_r  <= in_data.voltage_d;
      vq_r  <= in_data.voltage_q;
      w_r   <= in_data.electrical_speed;
      sat_r <= 1'b0;
    end
    if (div_res.done && (state_r == S_DIVD)) begin
      cur_d_r <= div_res.value;
      sat_r   <= sat_r | div_res.sat;
    end
    if (div_res.done && (state_r == S_DIVQ)) begin
      cur_q_r <= div_res.value;
      sat_r   <= sat_r | div_res.sat;
    end
    if (state_r == S_ACC) begin
      case (op_r)
        OP_R_ID: acc_d_r <= $signed({{20{vd_r[31]}}, vd_r, 12'd0}) - (p64 >>> 4);
        OP_W_FQ: acc_d_r <= acc_d_r + (p64 >>> 16);
        OP_R_IQ: acc_q_r <= $signed({{20{vq_r[31]}}, vq_r, 12'd0}) - (p64 >>> 4);
        OP_W_FD: acc_q_r <= acc_q_r - (p64 >>> 16);
        OP_HI_D: inc_d_r <= p64;
        OP_LO_D: inc_d_r <= inc_d_r + p_hi;
        OP_HI_Q: inc_q_r <= p64;
        OP_LO_Q: inc_q_r <= inc_q_r + p_hi;
        default: ;
      endcase
    end
    // magnitudes go to the ts multiplies, signs pick add or subtract
    if (state_r == S_MAG) begin
      acc_d_r <= acc_d_r[63] ? -acc_d_r : acc_d_r;
      acc_q_r <= acc_q_r[63] ? -acc_q_r : acc_q_r;
      sgn_d_r <= acc_d_r[63];
      sgn_q_r <= acc_q_r[63];
    end
    if (state_r == S_UPD) sat_r <= sat_r | cl_d.sat | cl_q.sat;
    if (out_load) begin
      out_data_r.current_d <= cur_d_r;
      out_data_r.current_q <= cur_q_r;
      out_data_r.saturated <= sat_r;
    end
  end

  a_div_done_state : assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> (state_r == S_DIVD || state_r == S_DIVQ))
    else $error("divider finished outside a division state");

  a_accept_starts : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_DIVD) && go_r && (op_r == OP_R_ID))
    else $error("accepted item did not start the divider");

  a_done_loads : assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r && (state_r == S_IDLE))
    else $error("result not placed in output register");

  a_update_last : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |-> (op_r == OP_LO_Q) && $past(state_r == S_ACC))
    else $error("flux updated before all passes");

endmodule

`default_nettype wire

@@ bench/pmsm_dq_plant_model_step_tb.sv @@
`timescale 1ns / 100ps

module pmsm_dq_plant_model_step_tb;
  import pdq_pkg::*;

  localparam int TB_DATA_WIDTH = DATA_WIDTH_DEF;
  localparam int SAT_BITS = (TB_DATA_WIDTH > 32) ? 32 : TB_DATA_WIDTH;
  localparam longint SAT_HI = (64'sd1 <<< (SAT_BITS - 1)) - 64'sd1;
  localparam int DUT_LATENCY = 78;
  localparam int LONG_HOLD = 400;
  localparam int unsigned LIMIT_CYCLES = 1000000;
  localparam int RAND_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 262;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [31:0] SMAX = 32'h7FFF_FFFF;
  localparam logic [31:0] SMIN = 32'h8000_0000;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0] cfg_data;

  bit idle_on;
  bit long_hold_req;
  bit long_hold_done;
  int unsigned cycle_count;

  pmsm_dq_plant_model_step #(.DATA_WIDTH(TB_DATA_WIDTH)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Plant state and registers mirrored here; one expected current pair per item.
  class dq_current_board;
    longint unsigned r_ohm;
    longint unsigned l_d;
    longint unsigned l_q;
    longint unsigned t_step;
    longint psi_pm;
    longint flux_d;
    longint flux_q;
    out_item_t expected_currents[$];
    int unsigned errors;
    int unsigned shown;

    function new();
      r_ohm = RESISTANCE_RST;
      l_d = INDUCTANCE_RST;
      l_q = INDUCTANCE_RST;
      t_step = SAMPLE_TIME_RST;
      psi_pm = longint'($signed(MAGNET_FLUX_RST));
      flux_d = 0;
      flux_q = 0;
      errors = 0;
      shown = 0;
    endfunction

    function void report(string what);
      errors++;
      if (shown < 10) begin
        $display("%0t: %s", $realtime, what);
        shown++;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
      case (idx)
        REG_RESISTANCE: r_ohm = val;
        REG_IND_D: l_d = val;
        REG_IND_Q: l_q = val;
        REG_SAMPLE_TIME: t_step = val;
        REG_MAGNET_FLUX: psi_pm = longint'($signed(val));
        default: ;
      endcase
    endfunction

    function longint clamp_sat(longint x, inout bit hit);
      if (x > SAT_HI) begin
        hit = 1'b1;
        return SAT_HI;
      end
      if (x < -SAT_HI - 1) begin
        hit = 1'b1;
        return -SAT_HI - 1;
      end
      return x;
    endfunction

    function longint flux_to_current(longint num_q28, longint unsigned l, inout bit hit);
      longint num;
      num = num_q28 <<< NUM_SHIFT;
      if (l == 0) begin
        if (num == 0) return 0;
        hit = 1'b1;
        return (num > 0) ? SAT_HI : -SAT_HI - 1;
      end
      return clamp_sat(num / longint'(l), hit);
    endfunction

    // increment taken on the magnitude, truncated, then signed
    function longint euler_advance(longint flux, longint deriv, inout bit hit);
      longint unsigned mag;
      longint unsigned inc;
      mag = (deriv < 0) ? -deriv : deriv;
      inc = (mag >> 32) * t_step + (((mag & 64'hFFFF_FFFF) * t_step) >> 32);
      return clamp_sat((deriv < 0) ? flux - longint'(inc) : flux + longint'(inc), hit);
    endfunction

    function void note_input(in_item_t it);
      longint vd;
      longint vq;
      longint w;
      longint id;
      longint iq;
      longint dd;
      longint dq;
      longint nd;
      longint nq;
      bit hit;
      out_item_t e;
      hit = 1'b0;
      vd = $signed(it.voltage_d);
      vq = $signed(it.voltage_q);
      w = $signed(it.electrical_speed);
      id = flux_to_current(flux_d - psi_pm, l_d, hit);
      iq = flux_to_current(flux_q, l_q, hit);
      // both derivatives from pre-update flux; product shifts floor
      dd = (vd <<< 12) - ((longint'(r_ohm) * id) >>> 4) + ((w * flux_q) >>> 16);
      dq = (vq <<< 12) - ((longint'(r_ohm) * iq) >>> 4) - ((w * flux_d) >>> 16);
      nd = euler_advance(flux_d, dd, hit);
      nq = euler_advance(flux_q, dq, hit);
      flux_d = nd;
      flux_q = nq;
      e.current_d = id[31:0];
      e.current_q = iq[31:0];
      e.saturated = hit;
      expected_currents.push_back(e);
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (expected_currents.size() == 0) begin
        report($sformatf("result with no item pending: d=%0d q=%0d sat=%0b",
                         got.current_d, got.current_q, got.saturated));
        return;
      end
      e = expected_currents.pop_front();
      if (got.current_d !== e.current_d || got.current_q !== e.current_q ||
          got.saturated !== e.saturated)
        report($sformatf("current mismatch: exp d=%0d q=%0d sat=%0b, got d=%0d q=%0d sat=%0b",
                         e.current_d, e.current_q, e.saturated,
                         got.current_d, got.current_q, got.saturated));
    endfunction
  endclass

  dq_current_board board = new();

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_result(out_data);
  end

  // result side: random hold-offs, plus one long one on request
  initial begin
    int unsigned hold;
    out_stall = 1'b0;
    long_hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req && !long_hold_done) begin
        long_hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
      end
      hold = idle_on ? $urandom_range(0, 6) : 0;
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  function automatic in_item_t pack_voltages(logic [31:0] vd, logic [31:0] vq,
                                             logic [31:0] w);
    in_item_t it;
    it.voltage_d = vd;
    it.voltage_q = vq;
    it.electrical_speed = w;
    return it;
  endfunction

  // mostly moderate levels so the flux wanders rather than pinning at the rails
  function automatic logic [31:0] draw_level();
    logic [31:0] v;
    int unsigned sh;
    case ($urandom_range(0, 9))
      0, 1, 2: v = $urandom;
      3, 4, 5, 6, 7: begin
        sh = $urandom_range(4, 26);
        v = $urandom & ((32'd1 << sh) - 32'd1);
        if ($urandom_range(0, 1) != 0) v = -v;
      end
      8: begin
        case ($urandom_range(0, 4))
          0: v = SMAX;
          1: v = SMIN;
          2: v = 32'd1;
          3: v = 32'hFFFF_FFFF;
          default: v = 32'd0;
        endcase
      end
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  task automatic send_item(input in_item_t it);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 6) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    board.note_input(it);
    @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_settings(input logic [31:0] r, input logic [31:0] ld,
                                input logic [31:0] lq, input logic [31:0] ts,
                                input logic [31:0] psi);
    cfg_write(REG_RESISTANCE, r);
    cfg_write(REG_IND_D, ld);
    cfg_write(REG_IND_Q, lq);
    cfg_write(REG_SAMPLE_TIME, ts);
    cfg_write(REG_MAGNET_FLUX, psi);
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    while (board.expected_currents.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  initial begin
    int ph;
    int n;
    int j;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    idle_on = 1'b1;
    long_hold_req = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // zero inductance while the flux is still cleared: zero numerators first
    cfg_write(REG_IND_D, 32'd0);
    cfg_write(REG_IND_Q, 32'd0);
    for (j = REG_SPARE_FIRST; j < 2 ** CFG_IDX_W; j++) cfg_write(CFG_IDX_W'(j), $urandom);
    send_item(pack_voltages(32'd0, 32'd0, 32'd0));
    send_item(pack_voltages(32'h03E8_0000, 32'hFC18_0000, 32'd0));
    send_item(pack_voltages(32'd0, 32'd0, 32'd0));
    wait_results();
    cfg_write(REG_MAGNET_FLUX, 32'h1000_0000);
    send_item(pack_voltages(32'hFC18_0000, 32'h03E8_0000, 32'h0001_0000));
    wait_results();

    apply_settings(RESISTANCE_RST, INDUCTANCE_RST, INDUCTANCE_RST, SAMPLE_TIME_RST,
                   32'h0199_999A);
    send_item(pack_voltages(SMAX, SMIN, 32'd0));
    send_item(pack_voltages(SMIN, SMAX, 32'd0));
    send_item(pack_voltages(32'd0, 32'd0, SMAX));
    send_item(pack_voltages(32'd0, 32'd0, SMIN));
    send_item(pack_voltages(SMAX, SMAX, SMAX));
    send_item(pack_voltages(SMIN, SMIN, SMIN));
    send_item(pack_voltages(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_item(pack_voltages(32'd1, 32'd1, 32'd1));
    send_item(pack_voltages(SMAX, 32'd0, SMIN));
    send_item(pack_voltages(32'd0, 32'd0, 32'd0));
    wait_results();
    // zero step: flux must hold still
    cfg_write(REG_SAMPLE_TIME, 32'd0);
    send_item(pack_voltages(SMAX, SMIN, SMAX));
    send_item(pack_voltages(32'd0, 32'd0, 32'd0));

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      wait_results();
      case (ph)
        0: apply_settings(RESISTANCE_RST, INDUCTANCE_RST, INDUCTANCE_RST, SAMPLE_TIME_RST,
                          MAGNET_FLUX_RST);
        1: apply_settings(32'd3277, 32'd2147484, 32'd3435974, 32'd42950, 32'd26843546);
        2: apply_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, SMAX);
        3: apply_settings(32'd1, 32'd1, 32'd1, 32'd1, SMIN);
        4: apply_settings(32'd0, 32'd858993, 32'd1288490, SAMPLE_TIME_RST, 32'hF000_0000);
        default: apply_settings($urandom, $urandom, $urandom, $urandom, $urandom);
      endcase
      // fill the block against a long result hold-off
      if (ph == 1) long_hold_req = 1'b1;
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 50 == 0) idle_on = ($urandom_range(0, 3) != 0);
        send_item(pack_voltages(draw_level(), draw_level(), draw_level()));
      end
    end

    wait_results();
    repeat (2 * DUT_LATENCY) @(negedge clk);
    if (board.expected_currents.size() != 0)
      board.report($sformatf("%0d items left without a result",
                             board.expected_currents.size()));
    if (board.errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
design/pdq_pkg.sv
design/pdq_div.sv
design/pdq_mul.sv
design/pmsm_dq_plant_model_step.sv
bench/pmsm_dq_plant_model_step_tb.sv
